// ===== rtl/min_coin_change_dp_assert.svh =====
// Assertion helpers used by the RTL datapath.
// Both macros expect clk and rst_n to be visible where they are used.
`ifndef MIN_COIN_CHANGE_DP_ASSERT_SVH
`define MIN_COIN_CHANGE_DP_ASSERT_SVH

// Same-cycle implication.
`define MCC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_coin_change_dp: assertion failed");

// Next-cycle implication.
`define MCC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_coin_change_dp: assertion failed");

`endif

// ===== rtl/mcc_pkg.sv =====
`default_nettype none

package mcc_pkg;

  // Table size and coin slots.
  localparam int MAX_AMOUNT = 1023;
  localparam int MAX_COINS  = 4;
  localparam int DEPTH      = MAX_AMOUNT + 1;
  localparam int AMT_W      = $clog2(DEPTH);

  // Field widths fixed by the interface.
  localparam int TARGET_W = 10;
  localparam int COIN_W   = 10;
  localparam int CNT_W    = 10;
  localparam int CIU_W    = 3;
  localparam int ENTRY_W  = CNT_W + 1;

  // Width used to compare amounts against coin values.
  localparam int WIDE_W = (AMT_W > COIN_W) ? AMT_W : COIN_W;
  localparam int SEL_W  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_COINS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_3 = 3'd4;

  // Register reset values.
  localparam logic [CIU_W-1:0]  RST_COINS_IN_USE = 3'd3;
  localparam logic [COIN_W-1:0] RST_COIN_0 = 10'd1;
  localparam logic [COIN_W-1:0] RST_COIN_1 = 10'd2;
  localparam logic [COIN_W-1:0] RST_COIN_2 = 10'd5;
  localparam logic [COIN_W-1:0] RST_COIN_3 = 10'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic scan;
    logic finish;
    logic emit;
  } mcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic short_path;
    logic last_coin;
    logic last_amt;
    logic out_free;
  } mcc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mcc_ctrl.sv =====
`default_nettype none

module mcc_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  mcc_pkg::mcc_sts_t sts,
  output mcc_pkg::mcc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Items are taken only between computations.
  assign in_stall = (state_r != S_IDLE);

  // Commands follow directly from the state.
  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.init   = (state_r == S_INIT);
    cmd.scan   = (state_r == S_SCAN);
    cmd.finish = (state_r == S_FINISH);
    cmd.emit   = (state_r == S_EMIT) && sts.out_free;
  end

  // Next state: scan each coin slot in turn, then finish the amount.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_INIT;
      end
      S_INIT: begin
        state_nxt = sts.short_path ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        if (sts.last_coin) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        state_nxt = sts.last_amt ? S_EMIT : S_SCAN;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcc_datapath.sv =====
`default_nettype none

`include "min_coin_change_dp_assert.svh"

module mcc_datapath (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [mcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [mcc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire  [mcc_pkg::TARGET_W-1:0]         in_target_amount,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [mcc_pkg::CNT_W-1:0]            out_fewest_coins,
  output logic                                 out_reachable,
  input  mcc_pkg::mcc_cmd_t                    cmd,
  output mcc_pkg::mcc_sts_t                    sts
);

  // Configuration registers.
  logic [mcc_pkg::CIU_W-1:0]  coins_in_use_r;
  logic [mcc_pkg::COIN_W-1:0] coin_value_r [mcc_pkg::MAX_COINS];

  // Working table, one entry per amount: reach bit over the coin count.
  logic [mcc_pkg::ENTRY_W-1:0] table_mem [mcc_pkg::DEPTH];
  logic [mcc_pkg::ENTRY_W-1:0] rdata_r;

  // Scan state.
  logic [mcc_pkg::AMT_W-1:0]  target_r;
  logic                       range_ok_r;
  logic [mcc_pkg::AMT_W-1:0]  amt_r;
  logic [mcc_pkg::SEL_W-1:0]  coin_sel_r;
  logic                       pend_r;
  logic                       found_r;
  logic [mcc_pkg::CNT_W-1:0]  best_r;
  logic                       res_found_r;
  logic [mcc_pkg::CNT_W-1:0]  res_cnt_r;

  // Output register.
  logic                       out_valid_r;
  logic [mcc_pkg::CNT_W-1:0]  out_cnt_r;
  logic                       out_reach_r;

  logic [mcc_pkg::CIU_W-1:0]  active_coins;
  logic                       slot_active;
  logic [mcc_pkg::COIN_W-1:0] coin;
  logic [mcc_pkg::WIDE_W-1:0] coin_w;
  logic [mcc_pkg::WIDE_W-1:0] amt_w;
  logic                       coin_use;
  logic [mcc_pkg::AMT_W-1:0]  rd_addr;
  logic                       cand_ok;
  logic [mcc_pkg::CNT_W-1:0]  prev_cnt;
  logic [mcc_pkg::CNT_W-1:0]  cand;
  logic                       base_found;
  logic                       acc_found;
  logic [mcc_pkg::CNT_W-1:0]  acc_best;
  logic [mcc_pkg::CNT_W-1:0]  acc_cnt;
  logic                       wr_en;
  logic [mcc_pkg::AMT_W-1:0]  wr_addr;
  logic [mcc_pkg::ENTRY_W-1:0] wr_data;
  logic                       range_ok;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coins_in_use_r  <= mcc_pkg::RST_COINS_IN_USE;
      coin_value_r[0] <= mcc_pkg::RST_COIN_0;
      coin_value_r[1] <= mcc_pkg::RST_COIN_1;
      coin_value_r[2] <= mcc_pkg::RST_COIN_2;
      coin_value_r[3] <= mcc_pkg::RST_COIN_3;
    end else if (cfg_we) begin
      case (cfg_index)
        mcc_pkg::CFG_COINS_IN_USE: coins_in_use_r  <= cfg_wdata[mcc_pkg::CIU_W-1:0];
        mcc_pkg::CFG_COIN_VALUE_0: coin_value_r[0] <= cfg_wdata[mcc_pkg::COIN_W-1:0];
        mcc_pkg::CFG_COIN_VALUE_1: coin_value_r[1] <= cfg_wdata[mcc_pkg::COIN_W-1:0];
        mcc_pkg::CFG_COIN_VALUE_2: coin_value_r[2] <= cfg_wdata[mcc_pkg::COIN_W-1:0];
        mcc_pkg::CFG_COIN_VALUE_3: coin_value_r[3] <= cfg_wdata[mcc_pkg::COIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The active coin count is clamped to the number of slots.
  assign active_coins = (coins_in_use_r > mcc_pkg::CIU_W'(mcc_pkg::MAX_COINS))
                        ? mcc_pkg::CIU_W'(mcc_pkg::MAX_COINS) : coins_in_use_r;
  assign slot_active  = (mcc_pkg::CIU_W'(coin_sel_r) < active_coins);

  // A coin takes part when its slot is active, it is nonzero and fits the amount.
  assign coin     = coin_value_r[coin_sel_r];
  assign coin_w   = mcc_pkg::WIDE_W'(coin);
  assign amt_w    = mcc_pkg::WIDE_W'(amt_r);
  assign coin_use = slot_active && (coin != '0) && (coin_w <= amt_w);
  assign rd_addr  = mcc_pkg::AMT_W'(amt_w - coin_w);

  // Candidate from the entry read in the previous cycle, saturated at the limit.
  assign cand_ok  = pend_r && rdata_r[mcc_pkg::CNT_W];
  assign prev_cnt = rdata_r[mcc_pkg::CNT_W-1:0];
  assign cand     = (prev_cnt == mcc_pkg::COUNT_LIMIT) ? mcc_pkg::COUNT_LIMIT
                                                       : prev_cnt + 1'b1;

  // Running minimum; the first slot of an amount starts from nothing found.
  assign base_found = (cmd.scan && (coin_sel_r == '0)) ? 1'b0 : found_r;
  assign acc_found  = base_found || cand_ok;
  assign acc_best   = (cand_ok && (!base_found || (cand < best_r))) ? cand : best_r;
  assign acc_cnt    = acc_found ? acc_best : '0;

  // Table write: entry zero at the start, each amount when its scan is done.
  assign wr_en   = cmd.init || cmd.finish;
  assign wr_addr = cmd.init ? '0 : amt_r;
  assign wr_data = cmd.init ? {1'b1, {mcc_pkg::CNT_W{1'b0}}} : {acc_found, acc_cnt};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rdata_r <= table_mem[rd_addr];
    end
  end

  assign range_ok = (mcc_pkg::WIDE_W'(in_target_amount) <= mcc_pkg::WIDE_W'(mcc_pkg::MAX_AMOUNT));

  // Target capture and amount and coin counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      range_ok_r  <= 1'b0;
      amt_r       <= '0;
      coin_sel_r  <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      res_found_r <= 1'b0;
    end else begin
      pend_r <= cmd.scan && coin_use;
      if (cmd.load) begin
        target_r   <= mcc_pkg::AMT_W'(in_target_amount);
        range_ok_r <= range_ok;
      end
      if (cmd.init) begin
        amt_r       <= mcc_pkg::AMT_W'(1);
        coin_sel_r  <= '0;
        found_r     <= 1'b0;
        res_found_r <= range_ok_r;
      end
      if (cmd.scan) begin
        coin_sel_r <= (coin_sel_r == mcc_pkg::SEL_W'(mcc_pkg::MAX_COINS - 1))
                      ? '0 : coin_sel_r + 1'b1;
        found_r    <= acc_found;
      end
      if (cmd.finish) begin
        amt_r       <= amt_r + 1'b1;
        found_r     <= 1'b0;
        res_found_r <= acc_found;
      end
    end
  end

  // Payload registers of the scan.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      best_r <= acc_best;
    end
    if (cmd.init) begin
      res_cnt_r <= '0;
    end else if (cmd.finish) begin
      res_cnt_r <= acc_cnt;
    end
  end

  // Output register holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cnt_r   <= res_cnt_r;
      out_reach_r <= res_found_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fewest_coins = out_cnt_r;
  assign out_reachable    = out_reach_r;

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.short_path = !range_ok_r || (target_r == '0);
    sts.last_coin  = (coin_sel_r == mcc_pkg::SEL_W'(mcc_pkg::MAX_COINS - 1));
    sts.last_amt   = (amt_r == target_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // A read always looks at a smaller amount that was filled earlier.
  `MCC_ASSERT_IMPL(a_rd_below_amt, cmd.scan && coin_use, rd_addr < amt_r)
  // A reachable nonzero amount needs at least one coin.
  `MCC_ASSERT_IMPL(a_reach_nonzero, cmd.finish && acc_found, acc_best != '0)
  // A pending result is never overwritten before it is taken.
  `MCC_ASSERT_IMPL(a_emit_free, cmd.emit, !(out_valid_r && out_stall))
  // After a finished amount short of the target, the next amount is scanned.
  `MCC_ASSERT_NEXT(a_next_amount, cmd.finish && !sts.last_amt, cmd.scan && (coin_sel_r == '0))

endmodule

`default_nettype wire

// ===== rtl/min_coin_change_dp.sv =====
// The table fill scans every coin slot for each amount from one up to the target
// and then writes that amount's entry; a zero or out-of-range target skips the fill.
// Throughput: one item per computation; the next item is taken once the result sits
// in the output register. Reset (rst_n low, synchronous) clears control state and
// restores coins_in_use = 3 and coin values 1, 2, 5, 1; the table needs no clearing.
`default_nettype none

module min_coin_change_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [mcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [mcc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [mcc_pkg::TARGET_W-1:0]     in_target_amount,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [mcc_pkg::CNT_W-1:0]        out_fewest_coins,
  output logic                             out_reachable
);

  mcc_pkg::mcc_cmd_t cmd;
  mcc_pkg::mcc_sts_t sts;

  // Sequencer.
  mcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, counters and output register.
  mcc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_target_amount (in_target_amount),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fewest_coins (out_fewest_coins),
    .out_reachable    (out_reachable),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

`default_nettype wire

// ===== dv/tb_min_coin_change_dp.sv =====
`default_nettype none

module tb_min_coin_change_dp;
  timeunit 1ns;
  timeprecision 1ps;

  // One result item as the block reports it.
  typedef struct packed {
    logic [mcc_pkg::CNT_W-1:0] coins;
    logic                      reach;
  } change_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_AMOUNT,
    ROW_AMOUNT_KNOWN
  } row_kind_t;

  // A row either writes a register or offers a target amount.
  typedef struct {
    row_kind_t                      kind;
    logic [mcc_pkg::CFG_IDX_W-1:0]  index;
    logic [mcc_pkg::CFG_DATA_W-1:0] value;
    change_t                        known;
  } stim_row_t;

  // Indexes past the last coin register; writes there must be ignored.
  localparam logic [mcc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [mcc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  // Index field of amount rows, which is not used.
  localparam logic [mcc_pkg::CFG_IDX_W-1:0] NO_REG = '0;
  localparam change_t UNREACHABLE = '{'0, 1'b0};
  localparam int LONG_HOLD = 120;
  localparam int RANDOM_PHASES = 8;
  localparam int AMOUNTS_PER_PHASE = 16;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [mcc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [mcc_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic [mcc_pkg::TARGET_W-1:0]     in_target_amount = '0;
  logic                             out_stall = 1'b0;
  wire                              in_stall;
  wire                              out_valid;
  wire [mcc_pkg::CNT_W-1:0]         out_fewest_coins;
  wire                              out_reachable;

  // Local copy of the coin configuration.
  logic [mcc_pkg::CIU_W-1:0]  slots_cfg;
  logic [mcc_pkg::COIN_W-1:0] denom [mcc_pkg::MAX_COINS];

  change_t pending_change [$];
  int      mismatches = 0;
  int      amounts_sent = 0;
  int      directed_sent = 0;
  int      reg_writes = 0;
  int      results_checked = 0;
  bit      hold_next = 1'b0;
  bit      no_idle = 1'b0;

  // Directed rows: reset coins first, then degenerate and extreme coin sets.
  stim_row_t plan [$] = '{
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd0, '{10'd0, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1, '{10'd1, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd10, '{10'd2, 1'b1}},
    '{ROW_AMOUNT, NO_REG, 10'd11, UNREACHABLE},
    '{ROW_AMOUNT, NO_REG, 10'd1023, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COINS_IN_USE, 10'd1, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1023, '{10'd1023, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd512, '{10'd512, 1'b1}},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_0, 10'd1023, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1023, '{10'd1, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1022, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COINS_IN_USE, 10'd0, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd0, '{10'd0, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd5, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COINS_IN_USE, 10'h3FF, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_0, 10'd0, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_1, 10'd3, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_2, 10'd7, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_3, 10'd1023, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd7, '{10'd1, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1023, '{10'd1, 1'b1}},
    '{ROW_AMOUNT, NO_REG, 10'd11, UNREACHABLE},
    '{ROW_AMOUNT, NO_REG, 10'd341, UNREACHABLE},
    '{ROW_CFG, CFG_SPARE_LO, 10'h3FF, UNREACHABLE},
    '{ROW_CFG, CFG_SPARE_HI, 10'h2AA, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1023, '{10'd1, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd2, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COINS_IN_USE, 10'd2, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_0, 10'd2, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_1, 10'd4, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1023, UNREACHABLE},
    '{ROW_AMOUNT, NO_REG, 10'd1022, UNREACHABLE},
    '{ROW_AMOUNT, NO_REG, 10'd6, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COINS_IN_USE, 10'd4, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_0, 10'd1023, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_1, 10'd1023, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_2, 10'd1023, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1023, '{10'd1, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1000, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COINS_IN_USE, 10'd5, UNREACHABLE},
    '{ROW_CFG, mcc_pkg::CFG_COIN_VALUE_3, 10'd1, UNREACHABLE},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1000, '{10'd1000, 1'b1}},
    '{ROW_AMOUNT_KNOWN, NO_REG, 10'd1023, '{10'd1, 1'b1}}
  };

  min_coin_change_dp dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_target_amount (in_target_amount),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fewest_coins (out_fewest_coins),
    .out_reachable    (out_reachable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(50_000_000);
    $display("FAIL min_coin_change_dp");
    $finish;
  end

  // Fewest coins for an amount: fill the count table bottom up over the active slots.
  function automatic change_t fewest_coins_for(input logic [mcc_pkg::TARGET_W-1:0] amount);
    logic [mcc_pkg::ENTRY_W-1:0] tab [mcc_pkg::DEPTH];
    int                          slots;
    int                          a;
    int                          j;
    int                          cand;
    int                          best;
    bit                          found;
    change_t                     res;
    slots = (int'(slots_cfg) > mcc_pkg::MAX_COINS) ? mcc_pkg::MAX_COINS : int'(slots_cfg);
    tab[0] = {1'b1, {mcc_pkg::CNT_W{1'b0}}};
    for (a = 1; a <= int'(amount); a++) begin
      found = 1'b0;
      best = 0;
      for (j = 0; j < slots; j++) begin
        if (denom[j] == '0 || int'(denom[j]) > a) continue;
        if (!tab[a - int'(denom[j])][mcc_pkg::CNT_W]) continue;
        cand = int'(tab[a - int'(denom[j])][mcc_pkg::CNT_W-1:0]) + 1;
        if (cand > int'(mcc_pkg::COUNT_LIMIT)) cand = int'(mcc_pkg::COUNT_LIMIT);
        if (!found || cand < best) begin
          best = cand;
          found = 1'b1;
        end
      end
      tab[a] = found ? {1'b1, mcc_pkg::CNT_W'(best)} : '0;
    end
    res.reach = tab[amount][mcc_pkg::CNT_W];
    res.coins = res.reach ? tab[amount][mcc_pkg::CNT_W-1:0] : '0;
    return res;
  endfunction

  // Mostly small amounts keep the table fill short; a few go to the top.
  function automatic logic [mcc_pkg::TARGET_W-1:0] pick_target();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '1;
    if (r == 1) return mcc_pkg::TARGET_W'($urandom_range(256, 1023));
    return mcc_pkg::TARGET_W'($urandom_range(0, 48));
  endfunction

  // Small denominations dominate so that many amounts are reachable.
  function automatic logic [mcc_pkg::COIN_W-1:0] pick_denom();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return mcc_pkg::COIN_W'($urandom_range(100, 1023));
    return mcc_pkg::COIN_W'($urandom_range(1, 12));
  endfunction

  // Register write; the local copy follows once the edge has passed.
  task automatic write_reg(input logic [mcc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    reg_writes++;
    case (idx)
      mcc_pkg::CFG_COINS_IN_USE: slots_cfg = val[mcc_pkg::CIU_W-1:0];
      mcc_pkg::CFG_COIN_VALUE_0: denom[0] = val;
      mcc_pkg::CFG_COIN_VALUE_1: denom[1] = val;
      mcc_pkg::CFG_COIN_VALUE_2: denom[2] = val;
      mcc_pkg::CFG_COIN_VALUE_3: denom[3] = val;
      default: ;
    endcase
  endtask

  // Stop offering items and wait until every expected result is back.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_change.size() != 0) @(posedge clk);
  endtask

  // Offer one target amount, after a random gap unless no_idle is set, and record its expected result.
  task automatic send_amount(input logic [mcc_pkg::TARGET_W-1:0] amount,
                             input bit use_known, input change_t known);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_amount <= amount;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_change.push_back(use_known ? known : fewest_coins_for(amount));
    amounts_sent++;
  endtask

  // Result side: random stalls, one long hold on request, field checks.
  initial begin : result_sink
    int      hold;
    change_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_next) begin
        hold = LONG_HOLD;
        hold_next = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_checked++;
      if (pending_change.size() == 0) begin
        $error("unexpected result item: fewest_coins %0d reachable %0b",
               out_fewest_coins, out_reachable);
        mismatches++;
      end else begin
        want = pending_change.pop_front();
        if (out_fewest_coins !== want.coins) begin
          $error("fewest_coins: expected %0d, got %0d", want.coins, out_fewest_coins);
          mismatches++;
        end
        if (out_reachable !== want.reach) begin
          $error("reachable: expected %0b, got %0b", want.reach, out_reachable);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int                        ph;
    int                        k;
    int unsigned               pick;
    logic [mcc_pkg::CIU_W-1:0] slots;
    slots_cfg = mcc_pkg::RST_COINS_IN_USE;
    denom[0] = mcc_pkg::RST_COIN_0;
    denom[1] = mcc_pkg::RST_COIN_1;
    denom[2] = mcc_pkg::RST_COIN_2;
    denom[3] = mcc_pkg::RST_COIN_3;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: register writes wait until the block is idle.
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        wait_until_idle();
        write_reg(plan[r].index, plan[r].value);
      end else begin
        cfg_we <= 1'b0;
        send_amount(plan[r].value, plan[r].kind == ROW_AMOUNT_KNOWN, plan[r].known);
        directed_sent++;
      end
    end

    // Random phases, each with a fresh coin set.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_until_idle();
      pick = $urandom_range(0, 9);
      if (pick == 0) slots = '0;
      else if (pick == 1) slots = mcc_pkg::CIU_W'($urandom_range(5, 7));
      else slots = mcc_pkg::CIU_W'($urandom_range(1, 4));
      write_reg(mcc_pkg::CFG_COINS_IN_USE,
                mcc_pkg::CFG_DATA_W'($urandom() & 32'h3F8) |
                mcc_pkg::CFG_DATA_W'(slots));
      write_reg(mcc_pkg::CFG_COIN_VALUE_0, pick_denom());
      write_reg(mcc_pkg::CFG_COIN_VALUE_1, pick_denom());
      write_reg(mcc_pkg::CFG_COIN_VALUE_2, pick_denom());
      write_reg(mcc_pkg::CFG_COIN_VALUE_3, pick_denom());
      if ($urandom_range(0, 2) == 0) begin
        write_reg(mcc_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  mcc_pkg::CFG_DATA_W'($urandom()));
      end
      cfg_we <= 1'b0;

      // Phases 2 and 5 run back to back; phase 5 also holds the result side off so
      // the block fills up and stalls its input.
      no_idle = (ph == 2) || (ph == 5);
      if (ph == 5) hold_next = 1'b1;
      for (k = 0; k < AMOUNTS_PER_PHASE; k++) begin
        send_amount((ph == 5) ? mcc_pkg::TARGET_W'($urandom_range(0, 3)) : pick_target(),
                    1'b0, UNREACHABLE);
      end
    end

    wait_until_idle();
    repeat (50) @(posedge clk);
    $display("Checked %0d results for %0d target amounts (%0d directed), %0d register writes.",
             results_checked, amounts_sent, directed_sent, reg_writes);
    $display("Coin sets spanned zero, clamped and full slot counts, zero and top coin values.");
    if (mismatches == 0) begin
      $display("PASS min_coin_change_dp");
    end else begin
      $display("FAIL min_coin_change_dp");
    end
    $finish;
  end

endmodule

`default_nettype wire
